// ----- design/jsu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared widths, character codes and the classified item passed from the
// front end to the decoder through the queue.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int unsigned CharW  = 21;
	localparam int unsigned UnitW  = 16;
	localparam int unsigned EscW   = 7;
	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW  = $clog2(QDepth);
	localparam int unsigned QCntW  = $clog2(QDepth + 1);

	localparam logic [CharW-1:0] ChQuote     = 21'h22;
	localparam logic [CharW-1:0] ChBackslash = 21'h5C;
	localparam logic [CharW-1:0] ChSlash     = 21'h2F;
	localparam logic [CharW-1:0] ChLetterB   = 21'h62;
	localparam logic [CharW-1:0] ChLetterF   = 21'h66;
	localparam logic [CharW-1:0] ChLetterN   = 21'h6E;
	localparam logic [CharW-1:0] ChLetterR   = 21'h72;
	localparam logic [CharW-1:0] ChLetterT   = 21'h74;
	localparam logic [CharW-1:0] ChLetterU   = 21'h75;

	localparam logic [UnitW-1:0] HiSurMin = 16'hD800;
	localparam logic [UnitW-1:0] HiSurMax = 16'hDBFF;
	localparam logic [UnitW-1:0] LoSurMin = 16'hDC00;
	localparam logic [UnitW-1:0] LoSurMax = 16'hDFFF;
	localparam logic [CharW-1:0] SuppBase = 21'h10000;

	typedef struct packed {
		logic [CharW-1:0] chr;
		logic             last;
		logic             is_bs;
		logic             is_u;
		logic             hex_ok;
		logic [3:0]       hex_val;
		logic             esc_ok;
		logic [EscW-1:0]  esc_cp;
	} item_t;

endpackage
`default_nettype wire

// ----- design/jsu_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape front end
// Accepts raw characters, classifies them (backslash, 'u', hex digit value,
// simple escape mapping) and registers the result for the queue.
// ----------------------------------------------------------------------------
module jsu_front (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire  [jsu_pkg::CharW-1:0]  in_char,
	input  wire                        in_last,
	output logic                       push_valid,
	output jsu_pkg::item_t             push_item,
	input  wire                        q_full
);

	jsu_pkg::item_t item_c;
	jsu_pkg::item_t item_s1;
	logic           valid_s1;
	logic           load;

	always_comb begin
		item_c         = '0;
		item_c.chr     = in_char;
		item_c.last    = in_last;
		item_c.is_bs   = (in_char == jsu_pkg::ChBackslash);
		item_c.is_u    = (in_char == jsu_pkg::ChLetterU);
		if (in_char >= 21'h30 && in_char <= 21'h39) begin
			item_c.hex_ok  = 1'b1;
			item_c.hex_val = in_char[3:0];
		end else if ((in_char >= 21'h41 && in_char <= 21'h46) ||
				(in_char >= 21'h61 && in_char <= 21'h66)) begin
			item_c.hex_ok  = 1'b1;
			item_c.hex_val = 4'(in_char[3:0] + 4'd9);
		end
		item_c.esc_ok = 1'b1;
		case (in_char)
			jsu_pkg::ChQuote:     item_c.esc_cp = 7'h22;
			jsu_pkg::ChBackslash: item_c.esc_cp = 7'h5C;
			jsu_pkg::ChSlash:     item_c.esc_cp = 7'h2F;
			jsu_pkg::ChLetterB:   item_c.esc_cp = 7'h08;
			jsu_pkg::ChLetterF:   item_c.esc_cp = 7'h0C;
			jsu_pkg::ChLetterN:   item_c.esc_cp = 7'h0A;
			jsu_pkg::ChLetterR:   item_c.esc_cp = 7'h0D;
			jsu_pkg::ChLetterT:   item_c.esc_cp = 7'h09;
			default: begin
				item_c.esc_ok = 1'b0;
				item_c.esc_cp = '0;
			end
		endcase
	end

	assign in_stall   = valid_s1 && q_full;
	assign load       = in_valid && !in_stall;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_c;
		end
	end

endmodule
`default_nettype wire

// ----- design/jsu_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape queue
// Short FIFO of classified items between the front end and the decoder.
// ----------------------------------------------------------------------------
module jsu_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push_valid,
	input  jsu_pkg::item_t  push_item,
	output logic            q_full,
	output logic            q_valid,
	output jsu_pkg::item_t  q_item,
	input  wire             pop
);

	jsu_pkg::item_t              mem_q [jsu_pkg::QDepth];
	logic [jsu_pkg::QPtrW-1:0]   wr_ptr_q;
	logic [jsu_pkg::QPtrW-1:0]   rd_ptr_q;
	logic [jsu_pkg::QCntW-1:0]   count_q;
	logic                        push;
	logic                        do_pop;

	function automatic logic [jsu_pkg::QPtrW-1:0] QPtrNext(
			input logic [jsu_pkg::QPtrW-1:0] p);
		QPtrNext = (p == jsu_pkg::QPtrW'(jsu_pkg::QDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	assign q_full  = (count_q == jsu_pkg::QCntW'(jsu_pkg::QDepth));
	assign q_valid = (count_q != '0);
	assign q_item  = mem_q[rd_ptr_q];
	assign push    = push_valid && !q_full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QPtrNext(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= QPtrNext(rd_ptr_q);
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= jsu_pkg::QCntW'(jsu_pkg::QDepth))
		else $error("queue count beyond depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || q_full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(q_full && !pop) |=> q_full)
		else $error("queue lost an entry without a pop");
`endif

endmodule
`default_nettype wire

// ----- design/jsu_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape decoder
// Runs the escape and surrogate state machine on classified items and holds
// one result in an output register.
// ----------------------------------------------------------------------------
module jsu_back (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        q_valid,
	input  jsu_pkg::item_t             q_item,
	output logic                       pop,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic [jsu_pkg::CharW-1:0]  out_code_point,
	output logic                       out_has_char,
	output logic                       out_error,
	output logic                       out_last
);

	typedef enum logic [2:0] {
		MODE_PLAIN   = 3'd0,
		MODE_ESC     = 3'd1,
		MODE_HEX_HI  = 3'd2,
		MODE_WANT_BS = 3'd3,
		MODE_WANT_U  = 3'd4,
		MODE_HEX_LO  = 3'd5
	} mode_t;

	mode_t                      mode_q, mode_d;
	logic [1:0]                 digit_q, digit_d;
	logic [jsu_pkg::UnitW-1:0]  high_q, high_d, high_shift;
	logic [jsu_pkg::UnitW-1:0]  low_q, low_d, low_shift;
	logic                       err_q, err_d;
	logic                       has_c;
	logic [jsu_pkg::CharW-1:0]  cp_c;
	logic [jsu_pkg::CharW-1:0]  pair_cp;
	logic                       out_valid_q;
	logic [jsu_pkg::CharW-1:0]  cp_q;
	logic                       has_q;
	logic                       err_out_q;
	logic                       last_q;

	assign high_shift = {high_q[11:0], q_item.hex_val};
	assign low_shift  = {low_q[11:0], q_item.hex_val};
	assign pair_cp    = jsu_pkg::SuppBase + {1'b0, high_q[9:0], low_shift[9:0]};
	assign pop        = q_valid && (!out_valid_q || !out_stall);

	always_comb begin
		mode_d  = mode_q;
		digit_d = digit_q;
		high_d  = high_q;
		low_d   = low_q;
		err_d   = err_q;
		has_c   = 1'b0;
		cp_c    = '0;
		if (!err_q) begin
			unique case (mode_q)
				MODE_ESC: begin
					mode_d = MODE_PLAIN;
					if (q_item.esc_ok) begin
						has_c = 1'b1;
						cp_c  = jsu_pkg::CharW'(q_item.esc_cp);
					end else if (q_item.is_u) begin
						mode_d  = MODE_HEX_HI;
						digit_d = '0;
						high_d  = '0;
					end else begin
						err_d = 1'b1;
					end
				end
				MODE_HEX_HI: begin
					if (!q_item.hex_ok) begin
						err_d = 1'b1;
					end else begin
						high_d = high_shift;
						if (digit_q == 2'd3) begin
							digit_d = '0;
							if (high_shift >= jsu_pkg::HiSurMin &&
									high_shift <= jsu_pkg::HiSurMax) begin
								mode_d = MODE_WANT_BS;
							end else begin
								mode_d = MODE_PLAIN;
								has_c  = 1'b1;
								cp_c   = jsu_pkg::CharW'(high_shift);
							end
						end else begin
							digit_d = digit_q + 2'd1;
						end
					end
				end
				MODE_WANT_BS: begin
					if (q_item.is_bs) begin
						mode_d = MODE_WANT_U;
					end else begin
						err_d = 1'b1;
					end
				end
				MODE_WANT_U: begin
					if (q_item.is_u) begin
						mode_d  = MODE_HEX_LO;
						digit_d = '0;
						low_d   = '0;
					end else begin
						err_d = 1'b1;
					end
				end
				MODE_HEX_LO: begin
					if (!q_item.hex_ok) begin
						err_d = 1'b1;
					end else begin
						low_d = low_shift;
						if (digit_q == 2'd3) begin
							digit_d = '0;
							mode_d  = MODE_PLAIN;
							if (low_shift >= jsu_pkg::LoSurMin &&
									low_shift <= jsu_pkg::LoSurMax) begin
								has_c = 1'b1;
								cp_c  = pair_cp;
							end else begin
								err_d = 1'b1;
							end
						end else begin
							digit_d = digit_q + 2'd1;
						end
					end
				end
				default: begin
					mode_d = MODE_PLAIN;
					if (q_item.is_bs) begin
						mode_d = MODE_ESC;
					end else begin
						has_c = 1'b1;
						cp_c  = q_item.chr;
					end
				end
			endcase
			if (q_item.last && !err_d && mode_d != MODE_PLAIN) begin
				err_d = 1'b1;
			end
		end
		if (err_d) begin
			has_c = 1'b0;
			cp_c  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_PLAIN;
			digit_q     <= '0;
			high_q      <= '0;
			low_q       <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (q_item.last) begin
					mode_q  <= MODE_PLAIN;
					digit_q <= '0;
					high_q  <= '0;
					low_q   <= '0;
					err_q   <= 1'b0;
				end else begin
					mode_q  <= mode_d;
					digit_q <= digit_d;
					high_q  <= high_d;
					low_q   <= low_d;
					err_q   <= err_d;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cp_q      <= cp_c;
			has_q     <= has_c;
			err_out_q <= err_d;
			last_q    <= q_item.last;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_code_point = cp_q;
	assign out_has_char   = has_q;
	assign out_error      = err_out_q;
	assign out_last       = last_q;

`ifndef NO_ASSERTIONS
	a_char_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && has_q) |-> !err_out_q)
		else $error("result carries a character and an error");
	a_empty_cp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !has_q) |-> (cp_q == '0))
		else $error("result without character has nonzero code point");
	a_digit_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(digit_q != 2'd0) |-> (mode_q == MODE_HEX_HI || mode_q == MODE_HEX_LO))
		else $error("digit count active outside hex mode");
	a_sticky_err: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && err_q && !q_item.last) |=> err_q)
		else $error("error flag dropped before string end");
`endif

endmodule
`default_nettype wire

// ----- design/json_string_unescape.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape
// Decodes the raw characters of JSON string bodies into code points.
// ----------------------------------------------------------------------------
// Input channel: one raw character per transfer (in_char, in_last), with
// in_valid/in_stall. in_last marks the final character of a string body.
// Output channel: exactly one result per input transfer, in order, with
// out_valid/out_stall: out_code_point/out_has_char when a character is
// complete, out_error once the string is malformed (sticky to string end),
// and out_last copied from the input.
// Throughput: one character per cycle while in_stall is low; the decoder
// state machine updates its mode, digit count and code units once per item.
// When nothing stalls, a result passes through the classify register, the
// queue and the output register in that order.
// A four-entry queue sits between the classifier and the decoder, so the
// input keeps taking characters for a while when the receiver stalls; the
// input stalls once the queue and classify register are full.
// Reset clears the queue, the output valid flag and all decode state; after
// each in_last result the decode state returns to its reset values.
// ----------------------------------------------------------------------------
module json_string_unescape (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire  [jsu_pkg::CharW-1:0]  in_char,
	input  wire                        in_last,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic [jsu_pkg::CharW-1:0]  out_code_point,
	output logic                       out_has_char,
	output logic                       out_error,
	output logic                       out_last
);

	logic           push_valid;
	jsu_pkg::item_t push_item;
	logic           q_full;
	logic           q_valid;
	jsu_pkg::item_t q_item;
	logic           pop;

	jsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_char    (in_char),
		.in_last    (in_last),
		.push_valid (push_valid),
		.push_item  (push_item),
		.q_full     (q_full)
	);

	jsu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.q_full     (q_full),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.pop        (pop)
	);

	jsu_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_code_point (out_code_point),
		.out_has_char   (out_has_char),
		.out_error      (out_error),
		.out_last       (out_last)
	);

endmodule
`default_nettype wire

// ----- dv/tb_json_string_unescape.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON string unescape testbench
// Drives raw string-body characters with random bursts and gaps and stalls
// the result side on its own pattern, including one long hold-off. Every
// result is checked in order against a behavioral decoder of escapes,
// \u code units, surrogate pairs and the sticky malformed flag.
// ----------------------------------------------------------------------------
module tb_json_string_unescape;

	typedef logic [jsu_pkg::CharW-1:0] char_t;
	typedef logic [jsu_pkg::UnitW-1:0] unit_t;

	typedef struct packed {
		char_t cp;
		logic  has_char;
		logic  error;
		logic  last;
	} result_t;

	typedef enum logic [2:0] {
		ModePlain,
		ModeEscape,
		ModeHexHigh,
		ModeWantBackslash,
		ModeWantU,
		ModeHexLow
	} decode_mode_t;

	localparam char_t ChDigit0 = 21'h30;
	localparam char_t ChDigit9 = 21'h39;
	localparam char_t ChUpperA = 21'h41;
	localparam char_t ChUpperF = 21'h46;
	localparam char_t ChLowerA = 21'h61;
	localparam char_t ChLowerF = 21'h66;
	localparam char_t ChLowerX = 21'h78;
	localparam char_t ChLowerG = 21'h67;
	localparam char_t ChLowerZ = 21'h7A;

	localparam char_t CpBackspace      = 21'h08;
	localparam char_t CpTab            = 21'h09;
	localparam char_t CpLineFeed       = 21'h0A;
	localparam char_t CpFormFeed       = 21'h0C;
	localparam char_t CpCarriageReturn = 21'h0D;

	localparam char_t EscLetters [8] = '{jsu_pkg::ChQuote, jsu_pkg::ChBackslash,
		jsu_pkg::ChSlash, jsu_pkg::ChLetterB, jsu_pkg::ChLetterF, jsu_pkg::ChLetterN,
		jsu_pkg::ChLetterR, jsu_pkg::ChLetterT};

	localparam int LongHold     = 200;
	localparam int RandomItems  = 1600;
	localparam int DrainLimit   = 20000;
	localparam int TimeoutNs    = 4_000_000;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_stall;
	char_t in_char;
	logic  in_last;
	logic  out_valid;
	logic  out_stall;
	char_t out_code_point;
	logic  out_has_char;
	logic  out_error;
	logic  out_last;

	json_string_unescape uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_char        (in_char),
		.in_last        (in_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_code_point (out_code_point),
		.out_has_char   (out_has_char),
		.out_error      (out_error),
		.out_last       (out_last)
	);

	// decoder state
	decode_mode_t mode       = ModePlain;
	logic [1:0]   digits     = '0;
	unit_t        unit_hi    = '0;
	unit_t        unit_lo    = '0;
	logic         bad_string = 1'b0;

	result_t decoded_q [$];
	result_t got;
	result_t want;

	int n_fail;
	int n_chars;
	int n_strings;
	int n_results;
	int n_flagged;
	int n_random;
	int burst_left;
	int gap_max;
	int hold_requests;
	int holds_taken;
	int hold_left;
	int pattern_left;
	int stall_pct;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(TimeoutNs);
		$display("FAILURE");
		$finish;
	end

	function automatic logic hex_nibble(input char_t c, output logic [3:0] v);
		v = '0;
		if (c >= ChDigit0 && c <= ChDigit9) begin
			v = 4'(c - ChDigit0);
			return 1'b1;
		end
		if (c >= ChUpperA && c <= ChUpperF) begin
			v = 4'(c - ChUpperA + 10);
			return 1'b1;
		end
		if (c >= ChLowerA && c <= ChLowerF) begin
			v = 4'(c - ChLowerA + 10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void unescape_char(input char_t c, input logic last);
		result_t    r;
		logic [3:0] nib;
		logic       is_hex;
		r = '0;
		r.last = last;
		is_hex = hex_nibble(c, nib);
		if (!bad_string) begin
			case (mode)
				ModeEscape: begin
					mode = ModePlain;
					r.has_char = 1'b1;
					case (c)
						jsu_pkg::ChQuote, jsu_pkg::ChBackslash, jsu_pkg::ChSlash: r.cp = c;
						jsu_pkg::ChLetterB: r.cp = CpBackspace;
						jsu_pkg::ChLetterF: r.cp = CpFormFeed;
						jsu_pkg::ChLetterN: r.cp = CpLineFeed;
						jsu_pkg::ChLetterR: r.cp = CpCarriageReturn;
						jsu_pkg::ChLetterT: r.cp = CpTab;
						jsu_pkg::ChLetterU: begin
							r.has_char = 1'b0;
							mode = ModeHexHigh;
							digits = '0;
							unit_hi = '0;
						end
						default: begin
							r.has_char = 1'b0;
							bad_string = 1'b1;
						end
					endcase
				end
				ModeHexHigh: begin
					if (!is_hex) begin
						bad_string = 1'b1;
					end else begin
						unit_hi = {unit_hi[11:0], nib};
						if (digits == 2'd3) begin
							digits = '0;
							if (unit_hi >= jsu_pkg::HiSurMin && unit_hi <= jsu_pkg::HiSurMax) begin
								mode = ModeWantBackslash;
							end else begin
								mode = ModePlain;
								r.has_char = 1'b1;
								r.cp = char_t'(unit_hi);
							end
						end else begin
							digits = digits + 2'd1;
						end
					end
				end
				ModeWantBackslash: begin
					if (c == jsu_pkg::ChBackslash) mode = ModeWantU;
					else bad_string = 1'b1;
				end
				ModeWantU: begin
					if (c == jsu_pkg::ChLetterU) begin
						mode = ModeHexLow;
						digits = '0;
						unit_lo = '0;
					end else begin
						bad_string = 1'b1;
					end
				end
				ModeHexLow: begin
					if (!is_hex) begin
						bad_string = 1'b1;
					end else begin
						unit_lo = {unit_lo[11:0], nib};
						if (digits == 2'd3) begin
							digits = '0;
							mode = ModePlain;
							if (unit_lo >= jsu_pkg::LoSurMin && unit_lo <= jsu_pkg::LoSurMax) begin
								r.has_char = 1'b1;
								r.cp = jsu_pkg::SuppBase + {1'b0, unit_hi[9:0], unit_lo[9:0]};
							end else begin
								bad_string = 1'b1;
							end
						end else begin
							digits = digits + 2'd1;
						end
					end
				end
				default: begin
					mode = ModePlain;
					if (c == jsu_pkg::ChBackslash) begin
						mode = ModeEscape;
					end else begin
						r.has_char = 1'b1;
						r.cp = c;
					end
				end
			endcase
			if (last && !bad_string && mode != ModePlain) bad_string = 1'b1;
		end
		if (bad_string) begin
			r.has_char = 1'b0;
			r.cp = '0;
		end
		r.error = bad_string;
		decoded_q.push_back(r);
		if (last) begin
			mode = ModePlain;
			digits = '0;
			unit_hi = '0;
			unit_lo = '0;
			bad_string = 1'b0;
		end
	endfunction

	function automatic char_t hex_char(input logic [3:0] v, input logic upper);
		if (v < 4'd10) return ChDigit0 + char_t'(v);
		return (upper ? ChUpperA : ChLowerA) + char_t'(v) - 21'd10;
	endfunction

	function automatic void push_u_escape(ref char_t s[$], input unit_t unit);
		s.push_back(jsu_pkg::ChBackslash);
		s.push_back(jsu_pkg::ChLetterU);
		for (int i = 3; i >= 0; i--) s.push_back(hex_char(unit[i*4 +: 4], 1'($urandom_range(1))));
	endfunction

	// one character transfer, with sender bursts and gaps
	task automatic send_char(input char_t c, input logic last);
		int gap;
		if (burst_left <= 0) begin
			gap = $urandom_range(gap_max);
			burst_left = $urandom_range(1, 16);
			if (gap != 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid = 1'b1;
		in_char = c;
		in_last = last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		unescape_char(c, last);
		n_chars++;
		@(negedge clk);
	endtask

	task automatic send_string(input char_t s[$]);
		for (int i = 0; i < s.size(); i++) send_char(s[i], i == s.size() - 1);
		n_strings++;
	endtask

	function automatic void build_random_string(ref char_t s[$]);
		int    n_seg;
		int    kind;
		int    pos;
		unit_t unit;
		n_seg = $urandom_range(1, 8);
		for (int k = 0; k < n_seg; k++) begin
			kind = $urandom_range(99);
			if (kind < 35) begin
				case ($urandom_range(3))
					0: s.push_back(char_t'($urandom_range(21'h20, 21'h7E)));
					1: s.push_back(char_t'($urandom_range(21'hFFFF)));
					2: s.push_back(char_t'($urandom_range(21'h10000, 21'h10FFFF)));
					default: s.push_back(char_t'($urandom_range(21'h1FFFFF)));
				endcase
			end else if (kind < 55) begin
				s.push_back(jsu_pkg::ChBackslash);
				s.push_back(EscLetters[$urandom_range(7)]);
			end else if (kind < 72) begin
				unit = unit_t'($urandom_range(16'hFFFF));
				if (unit >= jsu_pkg::HiSurMin && unit <= jsu_pkg::HiSurMax) unit = unit ^ 16'h4000;
				push_u_escape(s, unit);
			end else if (kind < 88) begin
				push_u_escape(s, jsu_pkg::HiSurMin + unit_t'($urandom_range(10'h3FF)));
				push_u_escape(s, jsu_pkg::LoSurMin + unit_t'($urandom_range(10'h3FF)));
			end else if (kind < 94) begin
				push_u_escape(s, jsu_pkg::LoSurMin + unit_t'($urandom_range(10'h3FF)));
			end else begin
				case ($urandom_range(5))
					0: begin
						s.push_back(jsu_pkg::ChBackslash);
						s.push_back($urandom_range(1) ? ChLowerX :
							char_t'($urandom_range(21'h1FFFFF)));
					end
					1: begin
						push_u_escape(s, unit_t'($urandom_range(16'hFFFF)));
						pos = s.size() - 1 - int'($urandom_range(3));
						s[pos] = char_t'($urandom_range(ChLowerG, ChLowerZ));
					end
					2: begin
						push_u_escape(s, jsu_pkg::HiSurMin + unit_t'($urandom_range(10'h3FF)));
						s.push_back(char_t'($urandom_range(21'h20, 21'h7E)));
					end
					3: begin
						push_u_escape(s, jsu_pkg::HiSurMin + unit_t'($urandom_range(10'h3FF)));
						s.push_back(jsu_pkg::ChBackslash);
						s.push_back(EscLetters[$urandom_range(7)]);
					end
					4: begin
						push_u_escape(s, jsu_pkg::HiSurMin + unit_t'($urandom_range(10'h3FF)));
						push_u_escape(s, unit_t'($urandom_range(16'hDBFF)));
					end
					default: begin
						push_u_escape(s, jsu_pkg::HiSurMin + unit_t'($urandom_range(10'h3FF)));
						repeat ($urandom_range(5)) void'(s.pop_back());
						return;
					end
				endcase
			end
		end
	endfunction

	task automatic test_plain_extremes();
		send_char('0, 1'b0);
		send_char(21'h1FFFFF, 1'b0);
		send_char(21'h10FFFF, 1'b1);
		n_strings++;
	endtask

	task automatic test_simple_escapes();
		char_t s[$];
		foreach (EscLetters[i]) begin
			s.push_back(jsu_pkg::ChBackslash);
			s.push_back(EscLetters[i]);
		end
		send_string(s);
	endtask

	task automatic test_surrogate_pair();
		char_t s[$];
		push_u_escape(s, jsu_pkg::HiSurMax);
		push_u_escape(s, jsu_pkg::LoSurMin);
		send_string(s);
	endtask

	task automatic test_malformed();
		char_t s[$];
		s = '{jsu_pkg::ChBackslash, ChLowerX, ChUpperA};
		send_string(s);
		s = '{jsu_pkg::ChBackslash};
		send_string(s);
	endtask

	task automatic test_random_strings(input int items);
		char_t s[$];
		int target;
		target = n_random + items;
		while (n_random < target) begin
			s.delete();
			build_random_string(s);
			case ($urandom_range(3))
				0: gap_max = 0;
				1: gap_max = 2;
				2: gap_max = 5;
				default: gap_max = 12;
			endcase
			send_string(s);
			n_random += s.size();
		end
	endtask

	task automatic test_backpressure();
		char_t s[$];
		hold_requests++;
		gap_max = 0;
		burst_left = 1000;
		repeat (4) begin
			s.delete();
			build_random_string(s);
			send_string(s);
		end
		burst_left = 0;
	endtask

	// result side stall pattern, with long holds on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && holds_taken != hold_requests) begin
				holds_taken++;
				hold_left = LongHold;
			end
			if (hold_left != 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				if (pattern_left == 0) begin
					pattern_left = $urandom_range(8, 64);
					case ($urandom_range(4))
						0, 1: stall_pct = 0;
						2: stall_pct = 30;
						3: stall_pct = 60;
						default: stall_pct = 90;
					endcase
				end
				pattern_left--;
				out_stall = ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got = '{out_code_point, out_has_char, out_error, out_last};
			n_results++;
			if (out_error) n_flagged++;
			if (decoded_q.size() == 0) begin
				n_fail++;
				if (n_fail <= 10)
					$display("unexpected result: cp=%h has_char=%b error=%b last=%b",
						got.cp, got.has_char, got.error, got.last);
			end else begin
				want = decoded_q.pop_front();
				if (got.cp !== want.cp || got.has_char !== want.has_char ||
					got.error !== want.error || got.last !== want.last) begin
					n_fail++;
					if (n_fail <= 10)
						$display("result %0d: expected %h/%b/%b/%b got %h/%b/%b/%b",
							n_results, want.cp, want.has_char, want.error, want.last,
							got.cp, got.has_char, got.error, got.last);
				end
			end
		end
	end

	initial begin
		int drain;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_char = '0;
		in_last = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_plain_extremes();
		test_simple_escapes();
		test_surrogate_pair();
		test_malformed();
		test_random_strings(RandomItems / 2);
		test_backpressure();
		test_random_strings(RandomItems / 2);
		in_valid = 1'b0;

		drain = 0;
		while (decoded_q.size() != 0 && drain < DrainLimit) begin
			@(posedge clk);
			drain++;
		end
		repeat (10) @(posedge clk);
		if (decoded_q.size() != 0) begin
			n_fail++;
			$display("%0d results never arrived", decoded_q.size());
		end

		$display("Sent %0d characters in %0d strings; checked %0d results, %0d malformed.",
			n_chars, n_strings, n_results, n_flagged);
		$display("Escapes, \\u units, surrogate pairs, broken escapes, long hold; %0d failures.",
			n_fail);
		if (n_fail == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/jsu_pkg.sv
design/jsu_front.sv
design/jsu_queue.sv
design/jsu_back.sv
design/json_string_unescape.sv
dv/tb_json_string_unescape.sv
